// ===== src/dtfb_pkg.sv =====
package dtfb_pkg;

	localparam int MAX_WIDTH  = 128;
	localparam int MAX_HEIGHT = 128;
	localparam int DEPTH_BITS = 24;

	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int IDX_W      = $clog2(STORE_SIZE);
	localparam int CNT_W      = $clog2(STORE_SIZE + 1);
	localparam int W_W        = $clog2(MAX_WIDTH + 1);
	localparam int H_W        = $clog2(MAX_HEIGHT + 1);

	localparam int COLOUR_W   = 32;
	localparam int SIZE_REG_W = 8;
	localparam int CDEPTH_W   = 24;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_COLOUR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CLEAR_DEPTH  = 2'd3;

	localparam logic [SIZE_REG_W-1:0] RESET_WIDTH        = 8'd128;
	localparam logic [SIZE_REG_W-1:0] RESET_HEIGHT       = 8'd128;
	localparam logic [COLOUR_W-1:0]   RESET_CLEAR_COLOUR = 32'h0000_0000;
	localparam logic [CDEPTH_W-1:0]   RESET_CLEAR_DEPTH  = 24'hFF_FFFF;

	// input command codes
	localparam logic [3:0] CMD_CLEAR_ALL    = 4'd0;
	localparam logic [3:0] CMD_CLEAR_COLOUR = 4'd1;
	localparam logic [3:0] CMD_CLEAR_DEPTH  = 4'd2;
	localparam logic [3:0] CMD_WRITE_COLOUR = 4'd3;
	localparam logic [3:0] CMD_ZTEST_WRITE  = 4'd4;
	localparam logic [3:0] CMD_DEPTH_UPDATE = 4'd5;
	localparam logic [3:0] CMD_ZTEST_QUERY  = 4'd6;
	localparam logic [3:0] CMD_FORCE_WRITE  = 4'd7;
	localparam logic [3:0] CMD_READ         = 4'd8;

	typedef logic [DEPTH_BITS-1:0] depth_t;

	typedef enum logic [3:0] {
		OP_CLEAR_ALL,
		OP_CLEAR_COLOUR,
		OP_CLEAR_DEPTH,
		OP_WRITE_COLOUR,
		OP_ZTEST_WRITE,
		OP_DEPTH_UPDATE,
		OP_ZTEST_QUERY,
		OP_FORCE_WRITE,
		OP_READ,
		OP_NONE
	} op_kind_t;

	typedef struct packed {
		logic [3:0]          cmd;
		logic [6:0]          pixel_x;
		logic [6:0]          pixel_y;
		logic [COLOUR_W-1:0] pixel_colour;
		logic [23:0]         pixel_depth;
	} in_item_t;

	typedef struct packed {
		logic                in_range;
		logic                test_passed;
		logic [COLOUR_W-1:0] colour_out;
	} result_t;

	// classified operation handed from front to back
	typedef struct packed {
		op_kind_t            kind;
		logic [IDX_W-1:0]    addr;
		logic [CNT_W-1:0]    count;
		logic [COLOUR_W-1:0] colour;
		depth_t              depth;
	} op_t;

endpackage

// ===== src/dtfb_ram.sv =====
module dtfb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/dtfb_front.sv =====
module dtfb_front import dtfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              item,
	output logic                  full,
	input  logic [SIZE_REG_W-1:0] width_in_use,
	input  logic [SIZE_REG_W-1:0] height_in_use,
	input  logic                  init_busy,
	output logic                  op_valid,
	output op_t                   op,
	input  logic                  op_pop
);

	logic [W_W-1:0]         w;
	logic [H_W-1:0]         h;
	logic                   in_frame;
	op_t                    new_op;
	logic                   push_ok;
	op_t                    q_mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wp_q;
	logic [QUEUE_PTR_W-1:0] rp_q;
	logic [QUEUE_CNT_W-1:0] cnt_q;

	// a zero size acts as one, an oversize acts as the maximum
	always_comb begin
		if (width_in_use == '0) begin
			w = W_W'(1);
		end else if (32'(width_in_use) > MAX_WIDTH) begin
			w = W_W'(MAX_WIDTH);
		end else begin
			w = W_W'(width_in_use);
		end
		if (height_in_use == '0) begin
			h = H_W'(1);
		end else if (32'(height_in_use) > MAX_HEIGHT) begin
			h = H_W'(MAX_HEIGHT);
		end else begin
			h = H_W'(height_in_use);
		end
	end

	assign in_frame = (32'(item.pixel_x) < 32'(w)) && (32'(item.pixel_y) < 32'(h));

	always_comb begin
		new_op.addr   = IDX_W'(CNT_W'(item.pixel_y) * CNT_W'(w) + CNT_W'(item.pixel_x));
		new_op.count  = CNT_W'(w) * CNT_W'(h);
		new_op.colour = item.pixel_colour;
		new_op.depth  = DEPTH_BITS'(item.pixel_depth);
		unique case (item.cmd)
			CMD_CLEAR_ALL:    new_op.kind = OP_CLEAR_ALL;
			CMD_CLEAR_COLOUR: new_op.kind = OP_CLEAR_COLOUR;
			CMD_CLEAR_DEPTH:  new_op.kind = OP_CLEAR_DEPTH;
			CMD_WRITE_COLOUR: new_op.kind = in_frame ? OP_WRITE_COLOUR : OP_NONE;
			CMD_ZTEST_WRITE:  new_op.kind = in_frame ? OP_ZTEST_WRITE : OP_NONE;
			CMD_DEPTH_UPDATE: new_op.kind = in_frame ? OP_DEPTH_UPDATE : OP_NONE;
			CMD_ZTEST_QUERY:  new_op.kind = in_frame ? OP_ZTEST_QUERY : OP_NONE;
			CMD_FORCE_WRITE:  new_op.kind = in_frame ? OP_FORCE_WRITE : OP_NONE;
			CMD_READ:         new_op.kind = in_frame ? OP_READ : OP_NONE;
			default:          new_op.kind = OP_NONE;
		endcase
	end

	assign full     = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH)) || init_busy;
	assign push_ok  = push && !full;
	assign op_valid = (cnt_q != '0);
	assign op       = q_mem[rp_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			q_mem[wp_q] <= new_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_ok) begin
				wp_q <= wp_q + QUEUE_PTR_W'(1);
			end
			if (op_pop) begin
				rp_q <= rp_q + QUEUE_PTR_W'(1);
			end
			if (push_ok && !op_pop) begin
				cnt_q <= cnt_q + QUEUE_CNT_W'(1);
			end else if (!push_ok && op_pop) begin
				cnt_q <= cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/dtfb_back.sv =====
module dtfb_back import dtfb_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                op_valid,
	input  op_t                 op,
	output logic                op_pop,
	input  logic [COLOUR_W-1:0] clear_colour,
	input  logic [CDEPTH_W-1:0] clear_depth,
	output logic                init_busy,
	output logic                empty,
	input  logic                pop,
	output result_t             result
);

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_CLEAR = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0]             state_q;
	logic [IDX_W-1:0]       cnt_q;
	op_t                    op_q;
	logic                   start;
	logic                   sweep_last;
	logic                   init_last;

	logic                   col_we;
	logic                   dep_we;
	logic [IDX_W-1:0]       waddr;
	logic [COLOUR_W-1:0]    col_wdata;
	depth_t                 dep_wdata;
	logic [COLOUR_W-1:0]    col_rdata;
	depth_t                 dep_rdata;

	logic                   res_push;
	result_t                res_new;
	result_t                res_mem [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] res_wp_q;
	logic [QUEUE_PTR_W-1:0] res_rp_q;
	logic [QUEUE_CNT_W-1:0] res_cnt_q;
	logic                   res_pop;

	// only one op in flight, so a free result slot at start is still free at the end
	assign start      = (state_q == ST_IDLE) && op_valid &&
	                    (res_cnt_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign op_pop     = start;
	assign init_busy  = (state_q == ST_INIT);
	assign sweep_last = (CNT_W'(cnt_q) == op_q.count - CNT_W'(1));
	assign init_last  = (cnt_q == IDX_W'(STORE_SIZE - 1));

	dtfb_ram #(.WIDTH(COLOUR_W), .DEPTH(STORE_SIZE)) u_colour_ram (
		.clk   (clk),
		.we    (col_we),
		.waddr (waddr),
		.wdata (col_wdata),
		.re    (start),
		.raddr (op.addr),
		.rdata (col_rdata)
	);

	dtfb_ram #(.WIDTH(DEPTH_BITS), .DEPTH(STORE_SIZE)) u_depth_ram (
		.clk   (clk),
		.we    (dep_we),
		.waddr (waddr),
		.wdata (dep_wdata),
		.re    (start),
		.raddr (op.addr),
		.rdata (dep_rdata)
	);

	always_comb begin
		col_we    = 1'b0;
		dep_we    = 1'b0;
		waddr     = cnt_q;
		col_wdata = op_q.colour;
		dep_wdata = op_q.depth;
		res_push  = 1'b0;
		res_new.in_range    = (op_q.kind != OP_NONE);
		res_new.test_passed = 1'b0;
		res_new.colour_out  = '0;
		unique case (state_q)
			ST_INIT: begin
				col_we    = 1'b1;
				dep_we    = 1'b1;
				col_wdata = RESET_CLEAR_COLOUR;
				dep_wdata = DEPTH_BITS'(RESET_CLEAR_DEPTH);
			end
			ST_CLEAR: begin
				col_we    = (op_q.kind != OP_CLEAR_DEPTH);
				dep_we    = (op_q.kind != OP_CLEAR_COLOUR);
				col_wdata = clear_colour;
				dep_wdata = DEPTH_BITS'(clear_depth);
				res_push  = sweep_last;
			end
			ST_EXEC: begin
				waddr    = op_q.addr;
				res_push = 1'b1;
				unique case (op_q.kind)
					OP_WRITE_COLOUR: col_we = 1'b1;
					OP_ZTEST_WRITE: begin
						res_new.test_passed = (op_q.depth < dep_rdata);
						col_we = res_new.test_passed;
						dep_we = res_new.test_passed;
					end
					OP_DEPTH_UPDATE: begin
						res_new.test_passed = (op_q.depth <= dep_rdata);
						dep_we = res_new.test_passed;
					end
					OP_ZTEST_QUERY: res_new.test_passed = (op_q.depth <= dep_rdata);
					OP_FORCE_WRITE: begin
						col_we = 1'b1;
						dep_we = 1'b1;
					end
					OP_READ: res_new.colour_out = col_rdata;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
		end
		if (res_push) begin
			res_mem[res_wp_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (init_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					cnt_q <= '0;
					if (start) begin
						if (op.kind == OP_CLEAR_ALL || op.kind == OP_CLEAR_COLOUR ||
						    op.kind == OP_CLEAR_DEPTH) begin
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_CLEAR: begin
					cnt_q <= cnt_q + IDX_W'(1);
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EXEC: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result queue
	assign empty   = (res_cnt_q == '0);
	assign res_pop = pop && !empty;
	assign result  = res_mem[res_rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wp_q  <= '0;
			res_rp_q  <= '0;
			res_cnt_q <= '0;
		end else begin
			if (res_push) begin
				res_wp_q <= res_wp_q + QUEUE_PTR_W'(1);
			end
			if (res_pop) begin
				res_rp_q <= res_rp_q + QUEUE_PTR_W'(1);
			end
			if (res_push && !res_pop) begin
				res_cnt_q <= res_cnt_q + QUEUE_CNT_W'(1);
			end else if (!res_push && res_pop) begin
				res_cnt_q <= res_cnt_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/depth_tested_framebuffer.sv =====
// Colour and depth framebuffer with z-test, 128 x 128 pixels maximum. Items go in through a
// two-beat command queue and results come back, one per item and in order, through a two-beat
// result queue. After reset the block sweeps both stores with the reset clear values, one pixel
// a cycle, and holds full high meanwhile; configuration writes are still taken.
// The executing sequencer handles one item at a time against single-port-write colour and depth
// memories: a pixel command is read, then tested and written; a clear sweeps every active pixel.
// Change configuration only while the block is idle.
module depth_tested_framebuffer import dtfb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  in_item_t              item,
	output logic                  full,
	output logic                  empty,
	input  logic                  pop,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [SIZE_REG_W-1:0] width_q;
	logic [SIZE_REG_W-1:0] height_q;
	logic [COLOUR_W-1:0]   clear_colour_q;
	logic [CDEPTH_W-1:0]   clear_depth_q;
	logic                  init_busy;
	logic                  op_valid;
	op_t                   op;
	logic                  op_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q        <= RESET_WIDTH;
			height_q       <= RESET_HEIGHT;
			clear_colour_q <= RESET_CLEAR_COLOUR;
			clear_depth_q  <= RESET_CLEAR_DEPTH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:        width_q        <= cfg_data[SIZE_REG_W-1:0];
				REG_HEIGHT:       height_q       <= cfg_data[SIZE_REG_W-1:0];
				REG_CLEAR_COLOUR: clear_colour_q <= cfg_data[COLOUR_W-1:0];
				REG_CLEAR_DEPTH:  clear_depth_q  <= cfg_data[CDEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	dtfb_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.item          (item),
		.full          (full),
		.width_in_use  (width_q),
		.height_in_use (height_q),
		.init_busy     (init_busy),
		.op_valid      (op_valid),
		.op            (op),
		.op_pop        (op_pop)
	);

	dtfb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.op_valid     (op_valid),
		.op           (op),
		.op_pop       (op_pop),
		.clear_colour (clear_colour_q),
		.clear_depth  (clear_depth_q),
		.init_busy    (init_busy),
		.empty        (empty),
		.pop          (pop),
		.result       (result)
	);

endmodule

// ===== sim/fb_check_pkg.sv =====
`timescale 1ns / 100ps
package fb_check_pkg;
	import dtfb_pkg::*;

	class fb_scoreboard;
		logic [COLOUR_W-1:0]   colour_mem [STORE_SIZE];
		depth_t                depth_mem [STORE_SIZE];
		logic [SIZE_REG_W-1:0] width_reg;
		logic [SIZE_REG_W-1:0] height_reg;
		logic [COLOUR_W-1:0]   clear_col;
		depth_t                clear_dep;
		result_t               pending_results [$];
		int                    errors;

		function new();
			width_reg  = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			clear_col  = RESET_CLEAR_COLOUR;
			clear_dep  = RESET_CLEAR_DEPTH;
			errors     = 0;
			// reset sweep covers the whole store, not just the active area
			for (int i = 0; i < STORE_SIZE; i++) begin
				colour_mem[i] = RESET_CLEAR_COLOUR;
				depth_mem[i]  = RESET_CLEAR_DEPTH;
			end
		endfunction

		function int active_w();
			if (width_reg == 0)
				return 1;
			if (width_reg > MAX_WIDTH)
				return MAX_WIDTH;
			return int'(width_reg);
		endfunction

		function int active_h();
			if (height_reg == 0)
				return 1;
			if (height_reg > MAX_HEIGHT)
				return MAX_HEIGHT;
			return int'(height_reg);
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_WIDTH: begin
					width_reg = data[SIZE_REG_W-1:0];
				end
				REG_HEIGHT: begin
					height_reg = data[SIZE_REG_W-1:0];
				end
				REG_CLEAR_COLOUR: begin
					clear_col = data[COLOUR_W-1:0];
				end
				REG_CLEAR_DEPTH: begin
					clear_dep = data[CDEPTH_W-1:0];
				end
				default: ;
			endcase
		endfunction

		// apply one accepted beat to the pixel stores and queue its result
		function void note_item(in_item_t it);
			result_t res;
			int      w;
			int      h;
			int      pix;
			w   = active_w();
			h   = active_h();
			res = '0;
			if (it.cmd == CMD_CLEAR_ALL || it.cmd == CMD_CLEAR_COLOUR ||
					it.cmd == CMD_CLEAR_DEPTH) begin
				for (int i = 0; i < w * h; i++) begin
					if (it.cmd != CMD_CLEAR_DEPTH)
						colour_mem[i] = clear_col;
					if (it.cmd != CMD_CLEAR_COLOUR)
						depth_mem[i] = clear_dep;
				end
				res.in_range = 1'b1;
			end else if (it.cmd <= CMD_READ && int'(it.pixel_x) < w &&
					int'(it.pixel_y) < h) begin
				pix = int'(it.pixel_x) + int'(it.pixel_y) * w;
				res.in_range = 1'b1;
				case (it.cmd)
					CMD_WRITE_COLOUR: begin
						colour_mem[pix] = it.pixel_colour;
					end
					CMD_ZTEST_WRITE: begin
						if (it.pixel_depth < depth_mem[pix]) begin
							depth_mem[pix]  = it.pixel_depth;
							colour_mem[pix] = it.pixel_colour;
							res.test_passed = 1'b1;
						end
					end
					CMD_DEPTH_UPDATE: begin
						if (it.pixel_depth <= depth_mem[pix]) begin
							depth_mem[pix]  = it.pixel_depth;
							res.test_passed = 1'b1;
						end
					end
					CMD_ZTEST_QUERY: begin
						res.test_passed = (it.pixel_depth <= depth_mem[pix]);
					end
					CMD_FORCE_WRITE: begin
						depth_mem[pix]  = it.pixel_depth;
						colour_mem[pix] = it.pixel_colour;
					end
					default: begin
						res.colour_out = colour_mem[pix];
					end
				endcase
			end
			pending_results.push_back(res);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with nothing expected, actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			if (got.in_range !== want.in_range) begin
				$display("%0t: in_range expected %b actual %b", $time,
					want.in_range, got.in_range);
				errors++;
			end
			if (got.test_passed !== want.test_passed) begin
				$display("%0t: test_passed expected %b actual %b", $time,
					want.test_passed, got.test_passed);
				errors++;
			end
			if (got.colour_out !== want.colour_out) begin
				$display("%0t: colour_out expected %h actual %h", $time,
					want.colour_out, got.colour_out);
				errors++;
			end
		endfunction
	endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
	import dtfb_pkg::*;
	import fb_check_pkg::*;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 400;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	in_item_t              item_in = '0;
	logic                  full;
	logic                  empty;
	logic                  pop = 1'b0;
	result_t               result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	fb_scoreboard sb = new();

	int          cycles = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int          hold_left = 0;
	int unsigned stall_mode = 0;
	int          mode_left = 0;
	int          burst_left = 1;
	int          pool_x [8];
	int          pool_y [8];
	depth_t      last_depth = '0;

	depth_tested_framebuffer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.item      (item_in),
		.full      (full),
		.empty     (empty),
		.pop       (pop),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL depth_tested_framebuffer");
			$finish;
		end
	end

	// beat monitor: both sides sampled at the edge that accepts them
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				sb.note_item(item_in);
			if (pop && !empty)
				sb.check_result(result);
		end
	end

	// receiver: changing stall pattern, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			pop <= 1'b0;
		end else if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			pop <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left  = $urandom_range(16, 96);
			end
			mode_left--;
			case (stall_mode)
				0: pop <= 1'b1;
				1: pop <= ($urandom_range(0, 3) != 0);
				2: pop <= ($urandom_range(0, 3) == 0);
				default: pop <= $urandom_range(0, 1);
			endcase
		end
	end

	function automatic in_item_t pixel_op(logic [3:0] cmd, int x, int y,
			logic [COLOUR_W-1:0] col, logic [23:0] dep);
		in_item_t it;
		it.cmd          = cmd;
		it.pixel_x      = 7'(x);
		it.pixel_y      = 7'(y);
		it.pixel_colour = col;
		it.pixel_depth  = dep;
		return it;
	endfunction

	function automatic in_item_t random_fragment();
		in_item_t it;
		int       w;
		int       h;
		int       pick;
		int       k;
		w = sb.active_w();
		h = sb.active_h();
		it.pixel_colour = $urandom;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, (w * h > 1024) ? 149 : 19) == 0)
			it.cmd = 4'($urandom_range(CMD_CLEAR_ALL, CMD_CLEAR_DEPTH));
		else if (pick < 4)
			it.cmd = 4'($urandom_range(int'(CMD_READ) + 1, 15));
		else
			it.cmd = 4'($urandom_range(CMD_WRITE_COLOUR, CMD_READ));
		// half the time revisit one of eight hot pixels so depth tests see their own history
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			k = $urandom_range(0, 7);
			it.pixel_x = 7'(pool_x[k]);
			it.pixel_y = 7'(pool_y[k]);
		end else if (pick < 85) begin
			it.pixel_x = 7'($urandom_range(0, w - 1));
			it.pixel_y = 7'($urandom_range(0, h - 1));
		end else begin
			it.pixel_x = 7'($urandom_range(0, 127));
			it.pixel_y = 7'($urandom_range(0, 127));
		end
		pick = $urandom_range(0, 99);
		if (pick < 10)
			it.pixel_depth = '0;
		else if (pick < 20)
			it.pixel_depth = 24'hFF_FFFF;
		else if (pick < 30)
			it.pixel_depth = last_depth;
		else
			it.pixel_depth = 24'($urandom);
		last_depth = it.pixel_depth;
		return it;
	endfunction

	task automatic send_item(in_item_t it);
		push    <= 1'b1;
		item_in <= it;
		do
			@(posedge clk);
		while (full);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task automatic set_frame(int w, int h, logic [COLOUR_W-1:0] col, logic [23:0] dep);
		write_reg(REG_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_HEIGHT, CFG_DATA_W'(h));
		write_reg(REG_CLEAR_COLOUR, col);
		write_reg(REG_CLEAR_DEPTH, CFG_DATA_W'(dep));
		cfg_we <= 1'b0;
		for (int i = 0; i < 8; i++) begin
			pool_x[i] = $urandom_range(0, sb.active_w() - 1);
			pool_y[i] = $urandom_range(0, sb.active_h() - 1);
		end
	endtask

	// block is idle once every result is back and a clear could have finished
	task automatic wait_idle();
		push <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (sb.active_w() * sb.active_h() + 4) @(posedge clk);
	endtask

	task automatic run_random(int count);
		int gap;
		for (int n = 0; n < count; n++) begin
			send_item(random_fragment());
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					push <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		// reset sweep holds full high
		do
			@(posedge clk);
		while (full);

		// directed checks on the reset frame
		send_item(pixel_op(CMD_READ, 0, 0, '1, '0));
		send_item(pixel_op(CMD_READ, 127, 127, '0, '1));
		send_item(pixel_op(CMD_ZTEST_QUERY, 5, 5, '0, 24'hFF_FFFF));
		send_item(pixel_op(CMD_ZTEST_WRITE, 5, 5, 32'h1234_5678, 24'hFF_FFFF));
		send_item(pixel_op(CMD_ZTEST_WRITE, 5, 5, 32'hFFFF_FFFF, 24'h00_0100));
		send_item(pixel_op(CMD_DEPTH_UPDATE, 5, 5, '0, 24'h00_0100));
		send_item(pixel_op(CMD_DEPTH_UPDATE, 5, 5, '0, 24'h00_0101));
		send_item(pixel_op(CMD_ZTEST_QUERY, 5, 5, '0, 24'h00_0000));
		send_item(pixel_op(CMD_READ, 5, 5, '0, '0));
		send_item(pixel_op(CMD_FORCE_WRITE, 5, 0, 32'hDEAD_BEEF, 24'hFF_FFFF));
		send_item(pixel_op(CMD_WRITE_COLOUR, 127, 127, 32'h8000_0001, '0));
		send_item(pixel_op(CMD_READ, 127, 127, '0, '0));
		send_item(pixel_op(4'd9, 5, 5, '1, '1));
		send_item(pixel_op(4'd15, 0, 0, '1, '1));
		wait_idle();

		// tiny frame: out-of-range pixels, stride change, clears
		set_frame(3, 2, 32'hA5A5_5A5A, 24'h00_0000);
		send_item(pixel_op(CMD_READ, 3, 0, '0, '0));
		send_item(pixel_op(CMD_DEPTH_UPDATE, 0, 2, '0, '0));
		send_item(pixel_op(CMD_ZTEST_QUERY, 127, 1, '0, '1));
		send_item(pixel_op(CMD_FORCE_WRITE, 2, 5, '1, '0));
		send_item(pixel_op(CMD_READ, 2, 1, '0, '0));
		send_item(pixel_op(CMD_CLEAR_COLOUR, 0, 0, '0, '0));
		send_item(pixel_op(CMD_ZTEST_QUERY, 2, 1, '0, 24'h00_0001));
		send_item(pixel_op(CMD_CLEAR_DEPTH, 0, 0, '0, '0));
		send_item(pixel_op(CMD_ZTEST_QUERY, 2, 1, '0, 24'h00_0000));
		send_item(pixel_op(CMD_CLEAR_ALL, 0, 0, '0, '0));
		send_item(pixel_op(CMD_READ, 2, 1, '0, '0));
		wait_idle();

		// random phases over a spread of frame settings
		set_frame(0, 0, $urandom, 24'h00_0000);
		run_random(100);
		wait_idle();
		set_frame(255, 1, 32'hFFFF_FFFF, 24'hFF_FFFF);
		run_random(100);
		wait_idle();
		set_frame(1, 255, $urandom, 24'($urandom));
		run_random(100);
		wait_idle();
		set_frame(16, 8, $urandom, 24'($urandom));
		hold_req = 1'b1;
		run_random(100);
		wait_idle();
		set_frame(128, 128, $urandom, 24'($urandom));
		run_random(100);
		wait_idle();
		set_frame(7, 13, $urandom, 24'h80_0000);
		run_random(100);
		wait_idle();
		set_frame(4, 4, 32'h0000_0000, 24'h00_0001);
		run_random(100);
		wait_idle();
		set_frame($urandom_range(1, 32), $urandom_range(1, 32), $urandom, 24'($urandom));
		run_random(100);
		wait_idle();
		set_frame($urandom_range(1, 32), $urandom_range(1, 32), $urandom, 24'($urandom));
		run_random(100);
		wait_idle();
		set_frame(200, 200, $urandom, 24'($urandom));
		run_random(100);
		wait_idle();
		set_frame($urandom_range(33, 128), $urandom_range(1, 8), $urandom, 24'($urandom));
		run_random(80);
		wait_idle();
		repeat (20) @(posedge clk);

		if (sb.errors == 0)
			$display("PASS depth_tested_framebuffer");
		else
			$display("FAIL depth_tested_framebuffer");
		$finish;
	end

endmodule
